FILE: hdl/tsac_pkg.sv
// ----------------------------------------------------------------------------
// tsac_pkg
// Sizes, row types, state codes and address decoding for the two-way cache.
// ----------------------------------------------------------------------------
package tsac_pkg;

  localparam int SETS       = 16;
  localparam int LINE_BYTES = 32;
  localparam int MEM_BLOCKS = 128;
  localparam int USE_WIDTH  = 16;

  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int SET_W   = $clog2(SETS);
  localparam int BLK_W   = $clog2(MEM_BLOCKS);
  localparam int TAG_W   = BLK_W - SET_W;
  localparam int LNUM_W  = ADDR_W + BLK_W;

  typedef logic [LINE_BYTES-1:0][BYTE_W-1:0] blk_row_t;
  typedef logic [1:0][LINE_BYTES-1:0][BYTE_W-1:0] line_row_t;

  // One row per set: tag and use count of both ways.
  typedef struct packed {
    logic [USE_WIDTH-1:0] use_b;
    logic [TAG_W-1:0]     tag_b;
    logic [USE_WIDTH-1:0] use_a;
    logic [TAG_W-1:0]     tag_a;
  } meta_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic WAY_A = 1'b0;
  localparam logic WAY_B = 1'b1;

  function automatic logic [BLK_W-1:0] addr_block(logic [ADDR_W-1:0] a);
    logic [LNUM_W-1:0] lnum;
    lnum = LNUM_W'(a) >> OFF_W;
    return lnum[BLK_W-1:0];
  endfunction

  function automatic logic [SET_W-1:0] addr_set(logic [ADDR_W-1:0] a);
    logic [BLK_W-1:0] b;
    b = addr_block(a);
    return b[SET_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] addr_tag(logic [ADDR_W-1:0] a);
    logic [BLK_W-1:0] b;
    b = addr_block(a);
    return b[BLK_W-1:SET_W];
  endfunction

  function automatic logic [OFF_W-1:0] addr_off(logic [ADDR_W-1:0] a);
    return a[OFF_W-1:0];
  endfunction

  function automatic logic [USE_WIDTH-1:0] bump(logic [USE_WIDTH-1:0] u);
    return (u == '1) ? u : u + USE_WIDTH'(1);
  endfunction

endpackage

FILE: hdl/tsac_ifs.sv
// ----------------------------------------------------------------------------
// tsac_req_if / tsac_rsp_if
// Valid/ready channels for cache requests and cache responses.
// ----------------------------------------------------------------------------
interface tsac_req_if import tsac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] write_value;

  modport source(output valid, op, address, write_value, input ready);
  modport sink(input valid, op, address, write_value, output ready);
endinterface

interface tsac_rsp_if import tsac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [BYTE_W-1:0]  read_data;
  logic [COUNT_W-1:0] miss_count;

  modport source(output valid, hit, read_data, miss_count, input ready);
  modport sink(input valid, hit, read_data, miss_count, output ready);
endinterface

FILE: hdl/tsac_ram.sv
// ----------------------------------------------------------------------------
// tsac_ram
// Simple dual-port synchronous RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module tsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/two_way_set_assoc_byte_cache_unit.sv
// ----------------------------------------------------------------------------
// two_way_set_assoc_byte_cache_unit
// Two-way set-associative write-through byte cache over a backing memory.
// Every access is a read-modify-write of the RAMs: in the cycle a request beat
// is accepted the set's tag/use-count row, the set's line row (both ways) and
// the addressed backing block are read from synchronous RAMs with registered
// reads; in the next cycle the tags are compared, the rows are modified and
// written back in one piece (a line fill moves a whole block at once) and the
// response is registered. A new request is accepted the cycle after that, so
// the next access is not taken before the current one has been written back.
// This lookup is held while an earlier response is still not taken.
// Valid bits per line and per backing block make all state read as zero
// right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_way_set_assoc_byte_cache_unit import tsac_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  tsac_req_if.sink       req,
  tsac_rsp_if.source     rsp
);

  state_t state;
  state_t state_next;

  logic              req_op;
  logic [ADDR_W-1:0] req_addr;
  logic [BYTE_W-1:0] req_wval;

  logic [SETS-1:0]       valid_a;
  logic [SETS-1:0]       valid_b;
  logic [MEM_BLOCKS-1:0] blk_valid;
  logic [COUNT_W-1:0]    misses;
  logic [COUNT_W-1:0]    misses_next;

  logic [ADDR_W-1:0] rd_addr;
  meta_t             meta_rd;
  meta_t             meta_wr;
  line_row_t         line_rd;
  line_row_t         line_wr;
  blk_row_t          blk_rd;
  blk_row_t          blk_wr;

  logic [BLK_W-1:0] blk;
  logic [SET_W-1:0] set;
  logic [TAG_W-1:0] tag;
  logic [OFF_W-1:0] off;

  logic                 hit_a;
  logic                 hit_b_raw;
  logic                 hit;
  logic                 way;
  logic [USE_WIDTH-1:0] use_a;
  logic [USE_WIDTH-1:0] use_b;
  blk_row_t             blk_cur;
  logic [BYTE_W-1:0]    data;
  logic                 proceed;
  logic                 commit;
  logic                 meta_we;
  logic                 line_we;
  logic                 blk_we;
  logic                 fill;

  assign rd_addr = (state == ST_IDLE) ? req.address : req_addr;
  assign req.ready = (state == ST_IDLE);

  assign blk = addr_block(req_addr);
  assign set = addr_set(req_addr);
  assign tag = addr_tag(req_addr);
  assign off = addr_off(req_addr);

  tsac_ram #(.WIDTH($bits(meta_t)), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (set),
    .wdata (meta_wr),
    .raddr (addr_set(rd_addr)),
    .rdata (meta_rd)
  );

  tsac_ram #(.WIDTH($bits(line_row_t)), .DEPTH(SETS)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (set),
    .wdata (line_wr),
    .raddr (addr_set(rd_addr)),
    .rdata (line_rd)
  );

  tsac_ram #(.WIDTH($bits(blk_row_t)), .DEPTH(MEM_BLOCKS)) u_back_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk),
    .wdata (blk_wr),
    .raddr (addr_block(rd_addr)),
    .rdata (blk_rd)
  );

  always_comb begin
    // Invalid ways read as a use count of zero.
    use_a     = valid_a[set] ? meta_rd.use_a : '0;
    use_b     = valid_b[set] ? meta_rd.use_b : '0;
    hit_a     = valid_a[set] && (meta_rd.tag_a == tag);
    hit_b_raw = valid_b[set] && (meta_rd.tag_b == tag);
    hit       = hit_a || hit_b_raw;
    if (hit_a) begin
      way = WAY_A;
    end else if (hit_b_raw) begin
      way = WAY_B;
    end else begin
      way = (use_a < use_b) ? WAY_A : WAY_B;
    end

    blk_cur = blk_valid[blk] ? blk_rd : '0;
    proceed = !rsp.valid || rsp.ready;
    commit  = (state == ST_LOOKUP) && proceed;

    meta_wr       = meta_rd;
    meta_wr.use_a = use_a;
    meta_wr.use_b = use_b;
    line_wr       = line_rd;
    blk_wr        = blk_cur;
    misses_next   = misses;
    fill          = 1'b0;
    data          = '0;
    meta_we       = 1'b0;
    line_we       = 1'b0;
    blk_we        = 1'b0;

    if (req_op == OP_READ) begin
      if (hit) begin
        meta_we = commit;
        data    = line_rd[way][off];
      end else begin
        fill          = 1'b1;
        meta_we       = commit;
        line_we       = commit;
        misses_next   = misses + COUNT_W'(1);
        line_wr[way]  = blk_cur;
        data          = blk_cur[off];
      end
    end else begin
      blk_we      = commit;
      blk_wr[off] = req_wval;
      if (hit) begin
        meta_we           = commit;
        line_we           = commit;
        line_wr[way][off] = req_wval;
      end else begin
        misses_next = misses + COUNT_W'(1);
      end
    end

    if (way == WAY_A) begin
      meta_wr.use_a = fill ? USE_WIDTH'(1) : bump(use_a);
      if (fill) begin
        meta_wr.tag_a = tag;
      end
    end else begin
      meta_wr.use_b = fill ? USE_WIDTH'(1) : bump(use_b);
      if (fill) begin
        meta_wr.tag_b = tag;
      end
    end

    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_LOOKUP;
      ST_LOOKUP: if (proceed) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid_a   <= '0;
      valid_b   <= '0;
      blk_valid <= '0;
      misses    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        misses    <= misses_next;
        rsp.valid <= 1'b1;
        if (blk_we) begin
          blk_valid[blk] <= 1'b1;
        end
        if (fill && way == WAY_A) begin
          valid_a[set] <= 1'b1;
        end
        if (fill && way == WAY_B) begin
          valid_b[set] <= 1'b1;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op   <= req.op;
      req_addr <= req.address;
      req_wval <= req.write_value;
    end
    if (commit) begin
      rsp.hit        <= hit;
      rsp.read_data  <= data;
      rsp.miss_count <= misses_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_single_way_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !(hit_a && hit_b_raw))
    else $error("both ways hold the same line");

  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    (commit && !hit) |=> (misses == $past(misses) + COUNT_W'(1)))
    else $error("miss not counted");

  a_hit_no_count: assert property (@(posedge clk) disable iff (rst)
    (commit && hit) |=> $stable(misses))
    else $error("miss counter moved on a hit");

  a_rsp_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_LOOKUP))
    else $error("response raised outside the lookup cycle");
`endif

endmodule
